### rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// Barometric pressure compensation package
// Types, register codes and arithmetic constants shared by the block.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int AddrW    = 5;
  localparam int DataW    = 64;
  localparam int DivSteps = 64;

  localparam logic [1:0] REG_TRIM_T_P1  = 2'd0;
  localparam logic [1:0] REG_TRIM_P2_P5 = 2'd1;
  localparam logic [1:0] REG_TRIM_P6_P9 = 2'd2;

  localparam logic signed [25:0] TempOff  = 26'sd128000;
  localparam logic [63:0]        DivBias  = 64'h0000_8000_0000_0000;
  localparam logic [63:0]        NumScale = 64'd3125;
  localparam logic [24:0]        PressMax = 25'h1FF_FFFF;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } bpc_trim_t;

  typedef struct packed {
    logic signed [15:0] temp;
    logic               ok;
    logic               neg;
  } bpc_side_t;

  typedef struct packed {
    logic [63:0] ma;
    logic [30:0] mb;
    bpc_side_t   side;
  } bpc_div_in_t;

  typedef struct packed {
    logic [63:0] quo;
    bpc_side_t   side;
  } bpc_div_out_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic        [24:0] pressure_q24_8;
    logic               result_valid;
  } bpc_result_t;

endpackage

### rtl/bpc_in_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Carries one raw pressure and temperature reading per beat.
// ----------------------------------------------------------------------------
interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_pressure;
  logic [19:0] raw_temperature;

  modport source (output valid, raw_pressure, raw_temperature, input ready);
  modport sink (input valid, raw_pressure, raw_temperature, output ready);
endinterface

### rtl/bpc_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Carries one compensated temperature and pressure per beat.
// ----------------------------------------------------------------------------
interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_centi;
  logic        [24:0] pressure_q24_8;
  logic               result_valid;

  modport source (output valid, temperature_centi, pressure_q24_8, result_valid,
                  input ready);
  modport sink (input valid, temperature_centi, pressure_q24_8, result_valid,
                output ready);
endinterface

### rtl/bpc_regs.sv
// ----------------------------------------------------------------------------
// Trim register file
// APB-style access to the three packed 64-bit trim registers.
// ----------------------------------------------------------------------------
module bpc_regs import bpc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output bpc_trim_t        trim
);

  logic [DataW-1:0] trim_t_p1;
  logic [DataW-1:0] trim_p2_p5;
  logic [DataW-1:0] trim_p6_p9;
  logic [1:0]       idx;
  logic             wr;

  assign idx    = paddr[AddrW-1:3];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_t_p1  <= '0;
      trim_p2_p5 <= '0;
      trim_p6_p9 <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_TRIM_T_P1:  trim_t_p1  <= pwdata;
        REG_TRIM_P2_P5: trim_p2_p5 <= pwdata;
        REG_TRIM_P6_P9: trim_p6_p9 <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TRIM_T_P1:  prdata = trim_t_p1;
      REG_TRIM_P2_P5: prdata = trim_p2_p5;
      REG_TRIM_P6_P9: prdata = trim_p6_p9;
      default:        prdata = '0;
    endcase
  end

  assign trim.t1 = trim_t_p1[15:0];
  assign trim.t2 = trim_t_p1[31:16];
  assign trim.t3 = trim_t_p1[47:32];
  assign trim.p1 = trim_t_p1[63:48];
  assign trim.p2 = trim_p2_p5[15:0];
  assign trim.p3 = trim_p2_p5[31:16];
  assign trim.p4 = trim_p2_p5[47:32];
  assign trim.p5 = trim_p2_p5[63:48];
  assign trim.p6 = trim_p6_p9[15:0];
  assign trim.p7 = trim_p6_p9[31:16];
  assign trim.p8 = trim_p6_p9[47:32];
  assign trim.p9 = trim_p6_p9[63:48];

endmodule

### rtl/bpc_front.sv
// ----------------------------------------------------------------------------
// Compensation front end
// Eleven stages: temperature, then the pressure dividend and divisor.
// ----------------------------------------------------------------------------
module bpc_front import bpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [19:0] raw_pressure,
  input  logic [19:0] raw_temperature,
  input  bpc_trim_t   trim,
  output logic        out_valid,
  output bpc_div_in_t dout
);

  function automatic logic signed [15:0] sat16(input logic signed [28:0] v);
    logic signed [15:0] r;
    if (v > 29'sd32767) r = 16'sh7FFF;
    else if (v < -29'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  logic [10:0] vld;

  logic signed [17:0] x1;
  logic signed [16:0] dt;
  logic        [20:0] np;
  logic signed [33:0] sq;
  logic signed [28:0] tr;
  logic signed [28:0] ts;
  logic signed [67:0] m_b6;
  logic signed [67:0] m_a3;
  logic        [47:0] pl;
  logic        [47:0] ph;
  logic        [63:0] prod;

  logic signed [17:0] s1_x1;
  logic signed [16:0] s1_d;
  logic        [20:0] s1_np;
  logic signed [33:0] s2_at;
  logic        [32:0] s2_dd;
  logic        [20:0] s2_np;
  logic signed [22:0] s3_at;
  logic signed [37:0] s3_bt;
  logic        [20:0] s3_np;
  logic signed [24:0] s4_tf;
  logic        [20:0] s4_np;
  logic signed [25:0] s5_ap;
  logic signed [15:0] s5_temp;
  logic        [20:0] s5_np;
  logic signed [51:0] s6_aa;
  logic signed [41:0] s6_a5;
  logic signed [41:0] s6_a2;
  logic signed [15:0] s6_temp;
  logic        [20:0] s6_np;
  logic        [63:0] s7_b6;
  logic        [63:0] s7_a3;
  logic signed [41:0] s7_a5;
  logic signed [41:0] s7_a2;
  logic signed [15:0] s7_temp;
  logic        [20:0] s7_np;
  logic        [63:0] s8_b;
  logic        [63:0] s8_v;
  logic signed [15:0] s8_temp;
  logic        [20:0] s8_np;
  logic        [47:0] s9_pl;
  logic        [31:0] s9_ph;
  logic        [63:0] s9_nm;
  logic signed [15:0] s9_temp;
  logic        [30:0] s10_d31;
  logic        [63:0] s10_num;
  logic signed [15:0] s10_temp;

  always_comb begin
    x1   = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, trim.t1, 1'b0});
    dt   = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, trim.t1});
    np   = 21'h10_0000 - {1'b0, raw_pressure};
    sq   = s1_d * s1_d;
    tr   = 29'(s4_tf * 29'sd5 + 29'sd128);
    ts   = tr >>> 8;
    m_b6 = s6_aa * trim.p6;
    m_a3 = s6_aa * trim.p3;
    pl   = s8_v[31:0] * trim.p1;
    ph   = s8_v[63:32] * trim.p1;
    prod = 64'(s9_pl) + {s9_ph, 32'h0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[9:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x1 <= x1;
      s1_d  <= dt;
      s1_np <= np;

      s2_at <= s1_x1 * trim.t2;
      s2_dd <= sq[32:0];
      s2_np <= s1_np;

      s3_at <= 23'(s2_at >>> 11);
      s3_bt <= $signed({1'b0, s2_dd[32:12]}) * trim.t3;
      s3_np <= s2_np;

      s4_tf <= 25'(s3_at + (s3_bt >>> 14));
      s4_np <= s3_np;

      s5_ap   <= 26'(s4_tf - TempOff);
      s5_temp <= sat16(ts);
      s5_np   <= s4_np;

      s6_aa   <= s5_ap * s5_ap;
      s6_a5   <= s5_ap * trim.p5;
      s6_a2   <= s5_ap * trim.p2;
      s6_temp <= s5_temp;
      s6_np   <= s5_np;

      s7_b6   <= m_b6[63:0];
      s7_a3   <= m_a3[63:0];
      s7_a5   <= s6_a5;
      s7_a2   <= s6_a2;
      s7_temp <= s6_temp;
      s7_np   <= s6_np;

      s8_b    <= s7_b6 + (64'(s7_a5) << 17) + (64'(trim.p4) << 35);
      s8_v    <= DivBias + 64'($signed(s7_a3) >>> 8) + (64'(s7_a2) << 12);
      s8_temp <= s7_temp;
      s8_np   <= s7_np;

      s9_pl   <= pl;
      s9_ph   <= ph[31:0];
      s9_nm   <= (64'(s8_np) << 31) - s8_b;
      s9_temp <= s8_temp;

      s10_d31  <= prod[63:33];
      s10_num  <= s9_nm * NumScale;
      s10_temp <= s9_temp;

      dout.ma        <= s10_num[63] ? (~s10_num + 64'd1) : s10_num;
      dout.mb        <= s10_d31[30] ? (~s10_d31 + 31'd1) : s10_d31;
      dout.side.temp <= s10_temp;
      dout.side.ok   <= |s10_d31;
      dout.side.neg  <= s10_num[63] ^ s10_d31[30];
    end
  end

  assign out_valid = vld[10];

endmodule

### rtl/bpc_div.sv
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division of magnitudes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bpc_div import bpc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  bpc_div_in_t  din,
  output logic         out_valid,
  output bpc_div_out_t dout
);

  typedef struct packed {
    logic [30:0] rem;
    logic [63:0] qd;
    logic [30:0] mb;
    bpc_side_t   side;
  } bpc_div_st_t;

  logic [DivSteps-1:0] vld;
  bpc_div_st_t         st [DivSteps];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DivSteps-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    bpc_div_st_t cur;
    bpc_div_st_t nxt;
    logic [31:0] t;
    logic        ge;

    if (k == 0) begin : g_first
      always_comb begin
        cur.rem  = '0;
        cur.qd   = din.ma;
        cur.mb   = din.mb;
        cur.side = din.side;
      end
    end else begin : g_next
      assign cur = st[k-1];
    end

    always_comb begin
      t        = {cur.rem, cur.qd[63]};
      ge       = t >= {1'b0, cur.mb};
      nxt.rem  = ge ? 31'(t - {1'b0, cur.mb}) : t[30:0];
      nxt.qd   = {cur.qd[62:0], ge};
      nxt.mb   = cur.mb;
      nxt.side = cur.side;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= nxt;
      end
    end
  end

  assign out_valid = vld[DivSteps-1];
  assign dout.quo  = st[DivSteps-1].qd;
  assign dout.side = st[DivSteps-1].side;

endmodule

### rtl/bpc_back.sv
// ----------------------------------------------------------------------------
// Compensation back end
// Six stages: quotient sign, second-order pressure terms and saturation.
// ----------------------------------------------------------------------------
module bpc_back import bpc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  bpc_div_out_t din,
  input  bpc_trim_t    trim,
  output logic         out_valid,
  output bpc_result_t  dout
);

  logic [5:0] vld;

  logic signed [63:0] s13;
  logic signed [66:0] m1w;
  logic        [63:0] y;
  logic        [63:0] m2;
  logic        [63:0] r;
  logic        [24:0] press;

  logic        [63:0] s0_p;
  bpc_side_t          s0_side;
  logic        [63:0] s1_p;
  logic        [63:0] s1_m1;
  logic signed [50:0] s1_s13;
  logic signed [48:0] s1_bl;
  logic signed [48:0] s1_bh;
  bpc_side_t          s1_side;
  logic        [63:0] s2_pp0;
  logic        [63:0] s2_pp1;
  logic        [63:0] s2_pp2;
  logic        [63:0] s2_b8;
  logic        [63:0] s2_p;
  bpc_side_t          s2_side;
  logic        [63:0] s3_a9;
  logic        [63:0] s3_sum;
  bpc_side_t          s3_side;
  logic        [63:0] s4_s;
  bpc_side_t          s4_side;

  always_comb begin
    s13 = $signed(s0_p) >>> 13;
    m1w = $signed(s13[50:0]) * trim.p9;
    y   = 64'(s1_s13);
    m2  = s2_pp0 + {32'(s2_pp1 + s2_pp2), 32'h0};
    r   = 64'($signed(s4_s) >>> 8) + (64'(trim.p7) << 4);
    if ($signed(r) < 64'sd0) press = '0;
    else if ($signed(r) > $signed(64'(PressMax))) press = PressMax;
    else press = r[24:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_p    <= din.side.neg ? (~din.quo + 64'd1) : din.quo;
      s0_side <= din.side;

      s1_p    <= s0_p;
      s1_m1   <= m1w[63:0];
      s1_s13  <= s13[50:0];
      s1_bl   <= $signed({1'b0, s0_p[31:0]}) * trim.p8;
      s1_bh   <= $signed({1'b0, s0_p[63:32]}) * trim.p8;
      s1_side <= s0_side;

      s2_pp0  <= s1_m1[31:0] * y[31:0];
      s2_pp1  <= s1_m1[31:0] * y[63:32];
      s2_pp2  <= s1_m1[63:32] * y[31:0];
      s2_b8   <= 64'(s1_bl) + {s1_bh[31:0], 32'h0};
      s2_p    <= s1_p;
      s2_side <= s1_side;

      s3_a9   <= 64'($signed(m2) >>> 25);
      s3_sum  <= s2_p + 64'($signed(s2_b8) >>> 19);
      s3_side <= s2_side;

      s4_s    <= s3_sum + s3_a9;
      s4_side <= s3_side;

      dout.temperature_centi <= s4_side.temp;
      dout.pressure_q24_8    <= s4_side.ok ? press : '0;
      dout.result_valid      <= s4_side.ok;
    end
  end

  assign out_valid = vld[5];

endmodule

### rtl/barometric_pressure_compensation.sv
// ----------------------------------------------------------------------------
// Barometric pressure compensation
// Pipelined temperature and pressure compensation with trim registers.
// ----------------------------------------------------------------------------
// The block takes one sample beat per clock while the skid register is empty,
// and returns one result beat per sample, in order. Each sample passes an
// 11-stage front end, the 64-stage divider, which forms one quotient bit per
// stage, a 6-stage back end and the output register. A skid register behind
// the output register lets one more beat drain while the output waits.
// Trim registers must be written while no sample is in flight.
module barometric_pressure_compensation import bpc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  bpc_in_if.sink           sample,
  bpc_out_if.source        result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  bpc_trim_t    trim;
  logic         en;
  logic         fv;
  bpc_div_in_t  fd;
  logic         dv;
  bpc_div_out_t dd;
  logic         bv;
  bpc_result_t  bd;

  logic         oval;
  bpc_result_t  od;
  logic         sv;
  bpc_result_t  sd;
  logic         out_free;

  bpc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .trim
  );

  bpc_front u_front (
    .clk, .rst, .en,
    .in_valid        (sample.valid),
    .raw_pressure    (sample.raw_pressure),
    .raw_temperature (sample.raw_temperature),
    .trim,
    .out_valid       (fv),
    .dout            (fd)
  );

  bpc_div u_div (
    .clk, .rst, .en,
    .in_valid  (fv),
    .din       (fd),
    .out_valid (dv),
    .dout      (dd)
  );

  bpc_back u_back (
    .clk, .rst, .en,
    .in_valid  (dv),
    .din       (dd),
    .trim,
    .out_valid (bv),
    .dout      (bd)
  );

  assign en           = !sv;
  assign sample.ready = en;
  assign out_free     = !oval || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      oval <= 1'b0;
      sv   <= 1'b0;
    end else if (sv) begin
      if (out_free) begin
        oval <= 1'b1;
        sv   <= 1'b0;
      end
    end else if (bv) begin
      if (out_free) oval <= 1'b1;
      else sv <= 1'b1;
    end else if (out_free) begin
      oval <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv && out_free) od <= sd;
    else if (!sv && bv && out_free) od <= bd;
    if (!sv && bv && !out_free) sd <= bd;
  end

  assign result.valid             = oval;
  assign result.temperature_centi = od.temperature_centi;
  assign result.pressure_q24_8    = od.pressure_q24_8;
  assign result.result_valid      = od.result_valid;

  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    sv |-> oval)
    else $error("skid register holds a beat while the output is empty");

  a_blocked_beat_kept: assert property (@(posedge clk) disable iff (rst)
    (!sv && bv && oval && !result.ready) |=> sv)
    else $error("beat leaving the pipeline was not caught by the skid register");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (oval && !od.result_valid) |-> (od.pressure_q24_8 == '0))
    else $error("invalid result carries a nonzero pressure");

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Barometric pressure compensation testbench
// Runs under several trim settings, from the all-zero reset values and all
// ones to real sensor trims written over the APB port. Under each setting it
// sends random raw readings, directed ones in some settings, with random gaps
// and stalls on both channels. Every sample is predicted in 64-bit integer
// arithmetic and each result beat is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bpc_pkg::*;

  typedef struct packed {
    logic [19:0] raw_p;
    logic [19:0] raw_t;
  } reading_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  bpc_in_if  sample();
  bpc_out_if result();

  barometric_pressure_compensation uut (
    .clk(clk), .rst(rst), .sample(sample.sink), .result(result.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  reading_t    readings_q[$];
  bpc_result_t compensated_q[$];
  logic [63:0] trim_reg [3];
  int          send_idle = 0, recv_idle = 0;
  int          errors = 0;
  int          quiet_cycles = 0;
  bit          took = 1;

  function automatic logic [63:0] asr(logic [63:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic bpc_result_t compensate(logic [19:0] raw_p, logic [19:0] raw_t);
    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] adc_p, adc_t, a, b, d, tf, p, dv, tw, na, nd, q;
    bpc_result_t r;
    t1 = {48'd0, trim_reg[0][15:0]};
    t2 = sx16(trim_reg[0][31:16]);
    t3 = sx16(trim_reg[0][47:32]);
    p1 = {48'd0, trim_reg[0][63:48]};
    p2 = sx16(trim_reg[1][15:0]);
    p3 = sx16(trim_reg[1][31:16]);
    p4 = sx16(trim_reg[1][47:32]);
    p5 = sx16(trim_reg[1][63:48]);
    p6 = sx16(trim_reg[2][15:0]);
    p7 = sx16(trim_reg[2][31:16]);
    p8 = sx16(trim_reg[2][47:32]);
    p9 = sx16(trim_reg[2][63:48]);
    adc_p = {44'd0, raw_p};
    adc_t = {44'd0, raw_t};

    a = asr(((adc_t >> 3) - (t1 << 1)) * t2, 11);
    d = (adc_t >> 4) - t1;
    b = asr(asr(d * d, 12) * t3, 14);
    tf = a + b;
    tw = asr(tf * 5 + 128, 8);
    if ($signed(tw) > 64'sd32767) tw = 64'd32767;
    if ($signed(tw) < -64'sd32768) tw = -64'sd32768;
    r.temperature_centi = tw[15:0];

    a = tf - 64'd128000;
    b = a * a * p6;
    b = b + ((a * p5) << 17);
    b = b + (p4 << 35);
    a = asr(a * a * p3, 8) + ((a * p2) << 12);
    dv = asr((DivBias + a) * p1, 33);

    if (dv == 0) begin
      r.result_valid = 1'b0;
      r.pressure_q24_8 = '0;
    end else begin
      p = 64'd1048576 - adc_p;
      na = ((p << 31) - b) * NumScale;
      nd = dv[63] ? -dv : dv;
      q = (na[63] ? -na : na) / nd;
      p = (na[63] != dv[63]) ? -q : q;
      a = asr(p9 * asr(p, 13) * asr(p, 13), 25);
      b = asr(p8 * p, 19);
      p = asr(p + a + b, 8) + (p7 << 4);
      if ($signed(p) < 0) p = 0;
      if ($signed(p) > $signed({39'd0, PressMax})) p = {39'd0, PressMax};
      r.result_valid = 1'b1;
      r.pressure_q24_8 = p[24:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    bpc_result_t want;
    if (sample.valid && sample.ready) begin
      compensated_q.push_back(compensate(sample.raw_pressure, sample.raw_temperature));
      took = 1;
    end
    if (result.valid && result.ready) begin
      if (compensated_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %h", $time,
                 {result.temperature_centi, result.pressure_q24_8, result.result_valid});
      end else begin
        want = compensated_q.pop_front();
        if (result.temperature_centi !== want.temperature_centi) begin
          errors++;
          $display("%0t: temperature_centi expected %0d actual %0d", $time,
                   want.temperature_centi, result.temperature_centi);
        end
        if (result.pressure_q24_8 !== want.pressure_q24_8) begin
          errors++;
          $display("%0t: pressure_q24_8 expected %h actual %h", $time,
                   want.pressure_q24_8, result.pressure_q24_8);
        end
        if (result.result_valid !== want.result_valid) begin
          errors++;
          $display("%0t: result_valid expected %b actual %b", $time,
                   want.result_valid, result.result_valid);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      sample.valid <= 0;
    end else if (took || !sample.valid) begin
      took = 0;
      if (readings_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        sample.valid <= 1;
        {sample.raw_pressure, sample.raw_temperature} <= readings_q.pop_front();
      end else begin
        sample.valid <= 0;
      end
    end
    result.ready <= !rst && $urandom_range(99) >= recv_idle;
  end

  always @(posedge clk) begin
    if ((sample.valid && sample.ready) || (result.valid && result.ready) ||
        (readings_q.size() == 0 && compensated_q.size() == 0 && !sample.valid))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("[barometric_pressure_compensation] ERROR");
      $finish;
    end
  end

  task automatic write_trim(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    psel = 1; pwrite = 1; penable = 0;
    paddr = AddrW'(idx) << 3;
    pwdata = val;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    trim_reg[idx] = val;
  endtask

  task automatic load_trims(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2);
    write_trim(REG_TRIM_T_P1, r0);
    write_trim(REG_TRIM_P2_P5, r1);
    write_trim(REG_TRIM_P6_P9, r2);
  endtask

  task automatic drain;
    wait (readings_q.size() == 0 && !sample.valid && compensated_q.size() == 0);
    repeat (5) @(negedge clk);
  endtask

  function automatic logic [63:0] pack4(int a, int b, int c, int d);
    return {d[15:0], c[15:0], b[15:0], a[15:0]};
  endfunction

  task automatic add_random(int n);
    reading_t rd;
    repeat (n) begin
      if ($urandom_range(3) == 0) begin
        rd.raw_p = 20'($urandom);
        rd.raw_t = 20'($urandom);
      end else begin
        rd.raw_p = 20'($urandom_range(600000, 200000));
        rd.raw_t = 20'($urandom_range(620000, 380000));
      end
      readings_q.push_back(rd);
    end
  endtask

  initial begin
    logic [63:0] real0, real1, real2;
    sample.valid = 0;
    sample.raw_pressure = '0;
    sample.raw_temperature = '0;
    result.ready = 0;
    trim_reg[0] = '0;
    trim_reg[1] = '0;
    trim_reg[2] = '0;
    real0 = pack4(27504, 26435, -1000, 36477);
    real1 = pack4(-10685, 3024, 2855, 140);
    real2 = pack4(-7, 15500, -14600, 6000);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Registers at reset value: zero divisor for every sample.
    send_idle = 37; recv_idle = 80;
    readings_q.push_back({20'h00000, 20'h00000});
    readings_q.push_back({20'hFFFFF, 20'hFFFFF});
    add_random(6);
    drain();

    load_trims(real0, real1, real2);
    readings_q.push_back({20'd415148, 20'd519888});
    readings_q.push_back({20'h00000, 20'h00000});
    readings_q.push_back({20'hFFFFF, 20'hFFFFF});
    readings_q.push_back({20'h00000, 20'hFFFFF});
    readings_q.push_back({20'hFFFFF, 20'h00000});
    readings_q.push_back({20'h80000, 20'h7FFFF});
    readings_q.push_back({20'h55555, 20'hAAAAA});
    readings_q.push_back({20'hAAAAA, 20'h55555});
    add_random(100);
    drain();

    load_trims(real0 & 64'h0000_FFFF_FFFF_FFFF, real1, real2);
    add_random(10);
    drain();

    load_trims('1, '1, '1);
    readings_q.push_back({20'h00000, 20'h00000});
    readings_q.push_back({20'hFFFFF, 20'hFFFFF});
    add_random(20);
    drain();

    send_idle = 80; recv_idle = 37;
    load_trims(pack4(32767, -32768, 32767, 1), pack4(32767, -32768, 32767, -32768),
               pack4(32767, -32768, 32767, -32768));
    add_random(20);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle = 0; recv_idle = 0;
      end
      load_trims(pack4(27504 + $urandom_range(2000) - 1000, 26435 + $urandom_range(2000) - 1000,
                       -1000 + $urandom_range(400) - 200, 36477 + $urandom_range(4000) - 2000),
                 pack4(-10685 + $urandom_range(2000) - 1000, 3024 + $urandom_range(400) - 200,
                       2855 + $urandom_range(400) - 200, 140 + $urandom_range(100) - 50),
                 pack4(-7 + $urandom_range(14) - 7, 15500 + $urandom_range(1000) - 500,
                       -14600 + $urandom_range(1000) - 500, 6000 + $urandom_range(1000) - 500));
      add_random(70);
      drain();
      load_trims({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      add_random(15);
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("[barometric_pressure_compensation] OK");
    else
      $display("[barometric_pressure_compensation] ERROR");
    $finish;
  end
endmodule
